/* design/goia_pkg.sv */
// shared types and constants for the generational object id allocator
// used by goia_ctrl, goia_datapath and generational_object_id_allocator
package goia_pkg;

    localparam int SLOTS_DEF       = 64;
    localparam int SERIAL_BITS_DEF = 16;
    localparam int REF_BITS_DEF    = 16;

    localparam int CLASS_W       = 4;
    localparam int HANDLE_W      = 32;
    localparam int SLOT_FIELD_W  = 6;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 4;
    localparam int IN_TDATA_W    = 80;
    localparam int OUT_TDATA_W   = 48;

    // input beat layout
    localparam int IN_OP_LSB     = 0;
    localparam int IN_ID_LSB     = 3;
    localparam int IN_SLOT_LSB   = 35;
    localparam int IN_MODE_LSB   = 73;
    localparam int IN_OK_LSB     = 75;

    typedef enum logic [2:0] {
        OP_ALLOC    = 3'd0,
        OP_FINALIZE = 3'd1,
        OP_LOOKUP   = 3'd2,
        OP_RELEASE  = 3'd3,
        OP_FREE     = 3'd4,
        OP_TO_INDEX = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_INVALID     = 3'd1,
        ST_NO_FREE     = 3'd2,
        ST_IN_USE      = 3'd3,
        ST_BAD_STATE   = 3'd4,
        ST_NOT_READY   = 3'd5,
        ST_WRONG_CLASS = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        LOCK_NONE      = 2'd0,
        LOCK_GLOBAL    = 2'd1,
        LOCK_REFCOUNT  = 2'd2,
        LOCK_EXCLUSIVE = 2'd3
    } lock_t;

    localparam logic [CFG_ADDR_W-1:0] CFG_CLASS_CODE    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SYSTEM_READY  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SHUTTING_DOWN = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_MOD,
        S_READ,
        S_EVAL,
        S_SCAN_STEP,
        S_SCAN_CHK,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic load_in;
        logic decode;
        logic mod_step;
        logic rd;
        logic eval;
        logic scan_step;
        logic scan_chk;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic pre_done;
        logic pre_scan;
        logic pre_mod;
        logic mod_last;
        logic scan_found;
        logic scan_last;
    } sts_t;

endpackage

/* design/generational_object_id_allocator.sv */
// top level of the generational object id allocator
// depends on goia_pkg, goia_ctrl, goia_datapath (which holds goia_ram)
//
// Handle table for one object class: one request beat in, one result beat out. After reset
// the table is cleared one slot a cycle, with s_tready low. Allocate scans the table
// round-robin from the last finalized serial, reading one slot at a time through the single
// table read port, until it finds a free slot or, when the table is full, has checked every
// slot. Lookup and to-index first reduce the serial mod SLOTS with a reciprocal multiply,
// then read the entry. Finalize, release and free read the entry at the given slot; requests
// refused up front skip the table. One request is in flight at a time; the next is taken
// once the result beat has been accepted.
module generational_object_id_allocator #(
    parameter int SLOTS       = goia_pkg::SLOTS_DEF,
    parameter int SERIAL_BITS = goia_pkg::SERIAL_BITS_DEF,
    parameter int REF_BITS    = goia_pkg::REF_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // operation[2:0], handle_in[34:3], slot_index[40:35], requester[72:41],
    // access_mode[74:73], op_succeeded[75], zero pad
    input  logic [goia_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[2:0], handle_out[34:3], slot_out[40:35], zero pad
    output logic [goia_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             cfg_we,
    input  logic [goia_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [goia_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    goia_pkg::cmd_t cmd;
    goia_pkg::sts_t sts;

    goia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    goia_datapath #(
        .SLOTS       (SLOTS),
        .SERIAL_BITS (SERIAL_BITS),
        .REF_BITS    (REF_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_tdata  (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_tdata (m_tdata)
    );

    // one request at a time: never ready while a result is pending
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("request accepted while a result is pending");

    // a refused request carries no handle
    a_fail_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2:0] != goia_pkg::ST_OK) |-> (m_tdata[34:3] == '0))
        else $error("failed result carries a handle");

    // a refused request carries no slot
    a_fail_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2:0] != goia_pkg::ST_OK) |-> (m_tdata[40:35] == '0))
        else $error("failed result carries a slot");

    // an accepted request is not answered in the cycle after it
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result appeared without processing");
endmodule

/* design/goia_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module goia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [AW-1:0]            raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end
endmodule

/* design/goia_ctrl.sv */
// sequencing state machine for the allocator
// depends on goia_pkg
module goia_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  goia_pkg::sts_t sts,
    output goia_pkg::cmd_t cmd
);
    goia_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= goia_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            goia_pkg::S_CLEAR:
                if (sts.clr_last) state_next = goia_pkg::S_IDLE;
            goia_pkg::S_IDLE:
                if (in_valid) state_next = goia_pkg::S_DECODE;
            goia_pkg::S_DECODE:
            begin
                if (sts.pre_done)      state_next = goia_pkg::S_DONE;
                else if (sts.pre_scan) state_next = goia_pkg::S_SCAN_STEP;
                else if (sts.pre_mod)  state_next = goia_pkg::S_MOD;
                else                   state_next = goia_pkg::S_READ;
            end
            goia_pkg::S_MOD:
                if (sts.mod_last) state_next = goia_pkg::S_READ;
            goia_pkg::S_READ:
                state_next = goia_pkg::S_EVAL;
            goia_pkg::S_EVAL:
                state_next = goia_pkg::S_DONE;
            goia_pkg::S_SCAN_STEP:
                state_next = goia_pkg::S_SCAN_CHK;
            goia_pkg::S_SCAN_CHK:
            begin
                if (sts.scan_found || sts.scan_last) state_next = goia_pkg::S_DONE;
                else                                 state_next = goia_pkg::S_SCAN_STEP;
            end
            goia_pkg::S_DONE:
                if (out_ready) state_next = goia_pkg::S_IDLE;
            default:
                state_next = goia_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            goia_pkg::S_CLEAR:     cmd.clr_step = 1'b1;
            goia_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            goia_pkg::S_DECODE:    cmd.decode    = 1'b1;
            goia_pkg::S_MOD:       cmd.mod_step  = 1'b1;
            goia_pkg::S_READ:      cmd.rd        = 1'b1;
            goia_pkg::S_EVAL:      cmd.eval      = 1'b1;
            goia_pkg::S_SCAN_STEP: cmd.scan_step = 1'b1;
            goia_pkg::S_SCAN_CHK:  cmd.scan_chk  = 1'b1;
            goia_pkg::S_DONE:      out_valid     = 1'b1;
            default:               cmd           = '0;
        endcase
    end
endmodule

/* design/goia_datapath.sv */
// handle table, config registers, modulo unit, scan counters and result register
// depends on goia_pkg and goia_ram
module goia_datapath #(
    parameter int SLOTS       = goia_pkg::SLOTS_DEF,
    parameter int SERIAL_BITS = goia_pkg::SERIAL_BITS_DEF,
    parameter int REF_BITS    = goia_pkg::REF_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [goia_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [goia_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [goia_pkg::IN_TDATA_W-1:0]      in_tdata,
    input  goia_pkg::cmd_t                       cmd,
    output goia_pkg::sts_t                       sts,
    output logic [goia_pkg::OUT_TDATA_W-1:0]     out_tdata
);
    localparam int AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW  = $clog2(SLOTS + 1);
    localparam int RW  = SERIAL_BITS + 1;
    localparam int CLW = goia_pkg::CLASS_W;
    localparam int WW  = REF_BITS + CLW + SERIAL_BITS;
    localparam int UW  = goia_pkg::HANDLE_W - SERIAL_BITS;
    localparam int SW  = goia_pkg::SLOT_FIELD_W;

    localparam logic [SERIAL_BITS-1:0] SMASK   = {SERIAL_BITS{1'b1}};
    localparam logic [REF_BITS-1:0]    REF_MAX = {REF_BITS{1'b1}};
    // floor(2^SERIAL_BITS / SLOTS), quotient estimate is exact or one low
    localparam logic [RW-1:0]          RECIP   = RW'((64'd1 << SERIAL_BITS) / 64'(SLOTS));

    // config registers
    logic [CLW-1:0] class_reg;
    logic           ready_reg;
    logic           shut_reg;

    // latched request
    goia_pkg::op_t   op_reg;
    goia_pkg::lock_t mode_reg;
    logic [31:0]     id_reg;
    logic [SW-1:0]   slot_in_reg;
    logic            ok_reg;

    logic [AW-1:0]          addr_reg;
    logic [SERIAL_BITS-1:0] sh_reg;
    logic [SERIAL_BITS-1:0] q_reg;
    logic                   mcnt_reg;
    logic [SERIAL_BITS-1:0] last_serial_reg;
    logic [AW-1:0]          last_slot_reg;
    logic [SERIAL_BITS-1:0] scan_serial_reg;
    logic [AW-1:0]          scan_slot_reg;
    logic [CW-1:0]          scan_cnt_reg;

    goia_pkg::status_t res_status_reg;
    logic [31:0]       res_handle_reg;
    logic [SW-1:0]     res_slot_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WW-1:0]     ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [WW-1:0]     ram_rdata;

    function automatic logic [31:0] mk_handle(input logic [CLW-1:0] cls,
                                              input logic [SERIAL_BITS-1:0] ser);
        mk_handle = (32'(cls) << SERIAL_BITS) | 32'(ser);
    endfunction

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg <= CLW'(1);
            ready_reg <= 1'b0;
            shut_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                goia_pkg::CFG_CLASS_CODE:    class_reg <= cfg_wdata;
                goia_pkg::CFG_SYSTEM_READY:  ready_reg <= cfg_wdata[0];
                goia_pkg::CFG_SHUTTING_DOWN: shut_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg      <= goia_pkg::op_t'(in_tdata[goia_pkg::IN_OP_LSB +: 3]);
            id_reg      <= in_tdata[goia_pkg::IN_ID_LSB +: 32];
            slot_in_reg <= in_tdata[goia_pkg::IN_SLOT_LSB +: SW];
            mode_reg    <= goia_pkg::lock_t'(in_tdata[goia_pkg::IN_MODE_LSB +: 2]);
            ok_reg      <= in_tdata[goia_pkg::IN_OK_LSB];
        end
    end

    // early checks that need no table access
    logic              class_match, slot_ok;
    logic              pre_done, pre_scan, pre_mod;
    goia_pkg::status_t pre_status;

    assign class_match = (id_reg[31:SERIAL_BITS] == UW'(class_reg));
    assign slot_ok     = (int'(slot_in_reg) < SLOTS);

    always_comb
    begin
        pre_done   = 1'b0;
        pre_scan   = 1'b0;
        pre_mod    = 1'b0;
        pre_status = goia_pkg::ST_OK;
        case (op_reg)
            goia_pkg::OP_ALLOC:
            begin
                if (!ready_reg || shut_reg)
                begin
                    pre_done = 1'b1; pre_status = goia_pkg::ST_NOT_READY;
                end
                else if (class_reg == '0)
                begin
                    pre_done = 1'b1; pre_status = goia_pkg::ST_WRONG_CLASS;
                end
                else pre_scan = 1'b1;
            end
            goia_pkg::OP_FINALIZE, goia_pkg::OP_RELEASE, goia_pkg::OP_FREE:
            begin
                if (!slot_ok)
                begin
                    pre_done = 1'b1; pre_status = goia_pkg::ST_INVALID;
                end
            end
            goia_pkg::OP_LOOKUP:
            begin
                if (!ready_reg)
                begin
                    pre_done = 1'b1; pre_status = goia_pkg::ST_NOT_READY;
                end
                else if (shut_reg && mode_reg != goia_pkg::LOCK_EXCLUSIVE)
                begin
                    pre_done = 1'b1; pre_status = goia_pkg::ST_BAD_STATE;
                end
                else if (class_reg == '0)
                begin
                    pre_done = 1'b1; pre_status = goia_pkg::ST_WRONG_CLASS;
                end
                else if (!class_match)
                begin
                    pre_done = 1'b1; pre_status = goia_pkg::ST_INVALID;
                end
                else pre_mod = 1'b1;
            end
            goia_pkg::OP_TO_INDEX:
            begin
                if (class_reg == '0 || !class_match)
                begin
                    pre_done = 1'b1; pre_status = goia_pkg::ST_WRONG_CLASS;
                end
                else pre_mod = 1'b1;
            end
            default:
            begin
                pre_done = 1'b1; pre_status = goia_pkg::ST_BAD_STATE;
            end
        endcase
    end

    // serial mod slots by reciprocal multiply: quotient estimate, then one correction
    logic [SERIAL_BITS+RW-1:0] prod;
    logic [31:0]               qd;
    logic [31:0]               diff;
    logic [AW-1:0]             rem_next;
    assign prod     = {{RW{1'b0}}, sh_reg} * {{SERIAL_BITS{1'b0}}, RECIP};
    assign qd       = 32'(q_reg) * 32'(SLOTS);
    assign diff     = 32'(sh_reg) - qd;
    assign rem_next = (diff >= 32'(SLOTS)) ? AW'(diff - 32'(SLOTS)) : AW'(diff);

    always_ff @(posedge clk)
    begin
        if (cmd.decode)
        begin
            sh_reg   <= id_reg[SERIAL_BITS-1:0];
            mcnt_reg <= 1'b0;
        end
        else if (cmd.mod_step)
        begin
            q_reg    <= prod[SERIAL_BITS +: SERIAL_BITS];
            mcnt_reg <= 1'b1;
        end
    end

    // round-robin serial and slot for the allocate scan
    logic [SERIAL_BITS:0]   s1;
    logic [AW-1:0]          slot1;
    logic [SERIAL_BITS-1:0] serial_nx;
    assign s1        = {1'b0, scan_serial_reg} + 1'b1;
    assign slot1     = (scan_slot_reg == AW'(SLOTS - 1)) ? '0 : scan_slot_reg + 1'b1;
    assign serial_nx = (s1 >= (SERIAL_BITS+1)'(SMASK)) ? SERIAL_BITS'(slot1)
                                                        : s1[SERIAL_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.decode)
        begin
            scan_serial_reg <= last_serial_reg;
            scan_slot_reg   <= last_slot_reg;
            scan_cnt_reg    <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_serial_reg <= serial_nx;
            scan_slot_reg   <= slot1;
            scan_cnt_reg    <= scan_cnt_reg + 1'b1;
        end
    end

    // fields of the word read back
    logic [REF_BITS-1:0]    r_refs;
    logic [CLW-1:0]         r_class;
    logic [SERIAL_BITS-1:0] r_serial;
    logic [31:0]            r_handle;
    assign r_refs   = ram_rdata[WW-1 -: REF_BITS];
    assign r_class  = ram_rdata[SERIAL_BITS +: CLW];
    assign r_serial = ram_rdata[SERIAL_BITS-1:0];
    assign r_handle = mk_handle(r_class, r_serial);

    // operation on the addressed entry
    goia_pkg::status_t ev_status;
    logic [31:0]       ev_handle;
    logic [SW-1:0]     ev_slot;
    logic              ev_we, ev_last;
    logic [WW-1:0]     ev_wdata;

    always_comb
    begin
        ev_status = goia_pkg::ST_OK;
        ev_handle = '0;
        ev_slot   = '0;
        ev_we     = 1'b0;
        ev_last   = 1'b0;
        ev_wdata  = ram_rdata;
        case (op_reg)
            goia_pkg::OP_FINALIZE:
            begin
                if (!ok_reg)
                begin
                    ev_we    = 1'b1;
                    ev_wdata = {r_refs, {(CLW+SERIAL_BITS){1'b0}}};
                end
                else if (r_class == '0)
                begin
                    ev_status = goia_pkg::ST_INVALID;
                end
                else
                begin
                    ev_last   = 1'b1;
                    ev_handle = r_handle;
                    ev_slot   = SW'(addr_reg);
                end
            end
            goia_pkg::OP_RELEASE:
            begin
                if (r_class == '0)
                begin
                    ev_status = goia_pkg::ST_INVALID;
                end
                else if (r_refs == '0)
                begin
                    ev_status = goia_pkg::ST_BAD_STATE;
                end
                else
                begin
                    ev_we     = 1'b1;
                    ev_wdata  = {r_refs - 1'b1, r_class, r_serial};
                    ev_handle = r_handle;
                    ev_slot   = SW'(addr_reg);
                end
            end
            goia_pkg::OP_FREE:
            begin
                if (r_class == '0)
                begin
                    ev_status = goia_pkg::ST_INVALID;
                end
                else
                begin
                    ev_we     = 1'b1;
                    ev_wdata  = '0;
                    ev_handle = r_handle;
                    ev_slot   = SW'(addr_reg);
                end
            end
            goia_pkg::OP_LOOKUP:
            begin
                if (r_handle != id_reg)
                begin
                    ev_status = goia_pkg::ST_INVALID;
                end
                else if (mode_reg == goia_pkg::LOCK_REFCOUNT && r_refs == REF_MAX)
                begin
                    ev_status = goia_pkg::ST_IN_USE;
                end
                else if (mode_reg == goia_pkg::LOCK_EXCLUSIVE && r_refs != '0)
                begin
                    ev_status = goia_pkg::ST_IN_USE;
                end
                else
                begin
                    ev_we     = (mode_reg == goia_pkg::LOCK_REFCOUNT);
                    ev_wdata  = {r_refs + 1'b1, r_class, r_serial};
                    ev_handle = id_reg;
                    ev_slot   = SW'(addr_reg);
                end
            end
            goia_pkg::OP_TO_INDEX:
            begin
                ev_slot = SW'(addr_reg);
            end
            default:
            begin
                ev_status = goia_pkg::ST_BAD_STATE;
            end
        endcase
    end

    // address register doubles as the clearing counter after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            addr_reg <= (addr_reg == AW'(SLOTS - 1)) ? '0 : addr_reg + 1'b1;
        end
        else if (cmd.decode)
        begin
            addr_reg <= AW'(slot_in_reg);
        end
        else if (cmd.mod_step && sts.mod_last)
        begin
            addr_reg <= rem_next;
        end
    end

    // last finalized serial and its slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_serial_reg <= '0;
            last_slot_reg   <= '0;
        end
        else if (cmd.eval && ev_last)
        begin
            last_serial_reg <= r_serial;
            last_slot_reg   <= addr_reg;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.decode && pre_done)
        begin
            res_status_reg <= pre_status;
            res_handle_reg <= '0;
            res_slot_reg   <= '0;
        end
        else if (cmd.eval)
        begin
            res_status_reg <= ev_status;
            res_handle_reg <= ev_handle;
            res_slot_reg   <= ev_slot;
        end
        else if (cmd.scan_chk && sts.scan_found)
        begin
            res_status_reg <= goia_pkg::ST_OK;
            res_handle_reg <= mk_handle(class_reg, scan_serial_reg);
            res_slot_reg   <= SW'(scan_slot_reg);
        end
        else if (cmd.scan_chk && sts.scan_last)
        begin
            res_status_reg <= goia_pkg::ST_NO_FREE;
            res_handle_reg <= '0;
            res_slot_reg   <= '0;
        end
    end

    // table port steering
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = ev_wdata;
        if (cmd.clr_step)
        begin
            ram_we    = 1'b1;
            ram_wdata = '0;
        end
        else if (cmd.eval)
        begin
            ram_we = ev_we;
        end
        else if (cmd.scan_chk && sts.scan_found)
        begin
            ram_we    = 1'b1;
            ram_waddr = scan_slot_reg;
            ram_wdata = {{REF_BITS{1'b0}}, class_reg, scan_serial_reg};
        end
    end

    assign ram_re    = cmd.rd || cmd.scan_step;
    assign ram_raddr = cmd.scan_step ? slot1 : addr_reg;

    goia_ram #(
        .WIDTH (WW),
        .DEPTH (SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // status toward the controller
    always_comb
    begin
        sts            = '0;
        sts.clr_last   = (addr_reg == AW'(SLOTS - 1));
        sts.pre_done   = pre_done;
        sts.pre_scan   = pre_scan;
        sts.pre_mod    = pre_mod;
        sts.mod_last   = mcnt_reg;
        sts.scan_found = (r_class == '0);
        sts.scan_last  = (scan_cnt_reg == CW'(SLOTS));
    end

    assign out_tdata = {{(goia_pkg::OUT_TDATA_W - 41){1'b0}},
                        res_slot_reg, res_handle_reg, res_status_reg};
endmodule
